[rtl/core/lr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Field widths of the request and pixel beats, request codes and the
// payload structs of the input register and of the path to the output stage.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int FIELD_BITS = 10;
  localparam int ADDR_BITS  = 20;

  // Request codes carried in req_type.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
  } line_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic                  last_pixel;
  } pixel_t;

endpackage
`default_nettype wire

[rtl/core/lr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lr_if: valid/ready channels of the line rasterizer
// lr_req_if carries load and step requests, lr_pix_if carries pixels.
// ----------------------------------------------------------------------------
interface lr_req_if import lr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [FIELD_BITS-1:0] start_x;
  logic [FIELD_BITS-1:0] start_y;
  logic [FIELD_BITS-1:0] end_x;
  logic [FIELD_BITS-1:0] end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pix_if import lr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] pixel_x;
  logic [FIELD_BITS-1:0] pixel_y;
  logic [ADDR_BITS-1:0]  pixel_addr;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_addr, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_addr, last_pixel, output ready);
endinterface
`default_nettype wire

[rtl/core/line_rasterizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer: integer Bresenham line engine
// Loads a line from two endpoints and emits one pixel per step request.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel. A beat with req_type REQ_LOAD
// sets up a new line from start and end points (dropping any line still in
// progress) and produces no pixel. A beat with req_type REQ_STEP produces
// the next pixel of the active line on the pix channel: its column, row,
// the frame buffer address row * SCREEN_WIDTH + column (20 bits, wrapping)
// and a last_pixel flag. The far endpoint is not drawn, a zero-length line
// draws nothing, and a step with no active line produces nothing.
// Timing: a request taken into the input register is processed when it
// leaves that register, and its pixel is registered in the output stage
// and offered on pix from there. One request is taken every cycle while
// the skid stage holds no pixel; the whole Bresenham update is a single pass
// of adds and compares between the input register and the output stage.
// Stalls: the output register plus a one-entry skid stage absorb a stalled
// receiver; req.ready falls only once both hold a pixel and the input
// register is full. Reset (rst, synchronous) empties all stages and leaves
// no line active.
// ----------------------------------------------------------------------------
module line_rasterizer import lr_pkg::*; #(
  parameter int SCREEN_WIDTH = 1024,
  parameter int COORD_BITS   = 10
) (
  input  logic clk,
  input  logic rst,
  lr_req_if.sink   req,
  lr_pix_if.source pix
);

  localparam int DEC_BITS = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Input register.
  logic      iv;
  line_req_t ireq;

  // Line state.
  coord_t              cur_x;
  coord_t              cur_y;
  coord_t              stop_major;
  coord_t              delta_major;
  coord_t              delta_minor;
  logic signed [DEC_BITS-1:0] decision;
  logic                steep_flag;
  logic                y_down_flag;
  logic                busy;

  logic   up_ready;
  logic   advance;
  logic   push;
  pixel_t pix_next;

  assign advance   = iv && up_ready;
  assign req.ready = !iv || up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (req.valid && req.ready) begin
      iv                <= 1'b1;
      ireq.req_type     <= req.req_type;
      ireq.start_x      <= req.start_x;
      ireq.start_y      <= req.start_y;
      ireq.end_x        <= req.end_x;
      ireq.end_y        <= req.end_y;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  // Load path: order the endpoints so x rises, then pick the major axis.
  coord_t ld_x0, ld_y0, ld_x1, ld_y1;
  coord_t ax0, ay0, ax1, ay1;
  coord_t ld_dx, ld_ady;
  logic   ld_down, ld_steep;
  coord_t ld_dmaj, ld_dmin;
  logic signed [DEC_BITS-1:0] ld_dec;

  always_comb begin
    ld_x0 = COORD_BITS'(ireq.start_x);
    ld_y0 = COORD_BITS'(ireq.start_y);
    ld_x1 = COORD_BITS'(ireq.end_x);
    ld_y1 = COORD_BITS'(ireq.end_y);
    if (ld_x1 < ld_x0) begin
      ax0 = ld_x1; ay0 = ld_y1; ax1 = ld_x0; ay1 = ld_y0;
    end else begin
      ax0 = ld_x0; ay0 = ld_y0; ax1 = ld_x1; ay1 = ld_y1;
    end
    ld_dx    = ax1 - ax0;
    ld_down  = (ay1 >= ay0);
    ld_ady   = ld_down ? (ay1 - ay0) : (ay0 - ay1);
    ld_steep = (ld_ady > ld_dx);
    ld_dmaj  = ld_steep ? ld_ady : ld_dx;
    ld_dmin  = ld_steep ? ld_dx : ld_ady;
    ld_dec   = $signed({2'b00, ld_dmin, 1'b0}) - $signed({3'b000, ld_dmaj});
  end

  // Step path: advance along the major axis, move the minor axis when the
  // decision term is not negative.
  logic   move_minor;
  coord_t y_stepped;
  coord_t st_x, st_y, st_major;
  logic   st_last;
  logic signed [DEC_BITS-1:0] st_dec;
  logic [FIELD_BITS-1:0] out_x, out_y;

  always_comb begin
    move_minor = !decision[DEC_BITS-1];
    st_dec = decision + $signed({2'b00, delta_minor, 1'b0});
    if (move_minor) begin
      st_dec = st_dec - $signed({2'b00, delta_major, 1'b0});
    end
    y_stepped = y_down_flag ? cur_y + 1'b1 : cur_y - 1'b1;
    if (steep_flag) begin
      st_x     = move_minor ? cur_x + 1'b1 : cur_x;
      st_y     = y_stepped;
      st_major = st_y;
    end else begin
      st_x     = cur_x + 1'b1;
      st_y     = move_minor ? y_stepped : cur_y;
      st_major = st_x;
    end
    st_last = (st_major == stop_major);

    out_x = FIELD_BITS'(cur_x);
    out_y = FIELD_BITS'(cur_y);
    pix_next.pixel_x    = out_x;
    pix_next.pixel_y    = out_y;
    pix_next.pixel_addr = ADDR_BITS'(ADDR_BITS'(out_y) * ADDR_BITS'(SCREEN_WIDTH))
                          + ADDR_BITS'(out_x);
    pix_next.last_pixel = st_last;
  end

  assign push = advance && (ireq.req_type == REQ_STEP) && busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      stop_major  <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      decision    <= '0;
      steep_flag  <= 1'b0;
      y_down_flag <= 1'b0;
      busy        <= 1'b0;
    end else if (advance && (ireq.req_type == REQ_LOAD)) begin
      cur_x       <= ax0;
      cur_y       <= ay0;
      stop_major  <= ld_steep ? ay1 : ax1;
      delta_major <= ld_dmaj;
      delta_minor <= ld_dmin;
      decision    <= ld_dec;
      steep_flag  <= ld_steep;
      y_down_flag <= ld_down;
      busy        <= (ld_dmaj != '0);
    end else if (push) begin
      cur_x    <= st_x;
      cur_y    <= st_y;
      decision <= st_dec;
      if (st_last) begin
        busy <= 1'b0;
      end
    end
  end

  lr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push),
    .push_data  (pix_next),
    .push_ready (up_ready),
    .pix        (pix)
  );

  // The major extent never falls below the minor one on an active line.
  a_major_dominates: assert property (@(posedge clk) disable iff (rst)
    busy |-> (delta_major >= delta_minor))
    else $error("active line has minor extent above major extent");

  // The final pixel of a line ends it.
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (push && pix_next.last_pixel) |=> !busy)
    else $error("line still active after its last pixel");

  // Back-pressure on requests only while the input register is occupied.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> iv)
    else $error("request channel stalled with empty input register");

endmodule
`default_nettype wire

[rtl/core/lr_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lr_skid: pixel output register with a skid stage
// Holds one pixel for the receiver and catches one more while it stalls,
// so the upstream ready is a plain register.
// ----------------------------------------------------------------------------
module lr_skid import lr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  pixel_t push_data,
  output logic   push_ready,
  lr_pix_if.source pix
);

  logic   main_valid;
  logic   skid_valid;
  pixel_t main_data;
  pixel_t skid_data;
  logic   pop;

  assign pop        = main_valid && pix.ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push_valid) begin
      if (main_valid && !pop) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end else begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign pix.valid      = main_valid;
  assign pix.pixel_x    = main_data.pixel_x;
  assign pix.pixel_y    = main_data.pixel_y;
  assign pix.pixel_addr = main_data.pixel_addr;
  assign pix.last_pixel = main_data.last_pixel;

endmodule
`default_nettype wire

[dv/lr_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pixel_checker: pixel scoreboard for the line rasterizer
// Watches the request and pixel channels, tracks the Bresenham walk of the
// active line and compares every pixel beat with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module lr_pixel_checker import lr_pkg::*; #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  lr_req_if    req,
  lr_pix_if    pix,
  output int   fail_count,
  output int   pending
);

  // Walk state of the line being drawn.
  logic [FIELD_BITS-1:0] cur_x, cur_y, stop_major;
  logic [FIELD_BITS-1:0] delta_major, delta_minor;
  logic signed [FIELD_BITS+2:0] decision;
  logic steep, y_down, line_active;

  pixel_t predicted_pixels[$];
  int     failures;

  initial begin
    failures   = 0;
    fail_count = 0;
    pending    = 0;
  end

  task automatic load_line(input line_req_t r);
    logic [FIELD_BITS-1:0] x0, y0, x1, y1, dx, ady;
    x0 = r.start_x;
    y0 = r.start_y;
    x1 = r.end_x;
    y1 = r.end_y;
    if (x1 < x0) begin
      {x0, x1} = {x1, x0};
      {y0, y1} = {y1, y0};
    end
    dx     = x1 - x0;
    y_down = (y1 >= y0);
    ady    = y_down ? y1 - y0 : y0 - y1;
    steep  = (ady > dx);
    cur_x  = x0;
    cur_y  = y0;
    if (steep) begin
      delta_major = ady;
      delta_minor = dx;
      stop_major  = y1;
    end else begin
      delta_major = dx;
      delta_minor = ady;
      stop_major  = x1;
    end
    decision    = (FIELD_BITS+3)'(2 * int'(delta_minor) - int'(delta_major));
    line_active = (delta_major != '0);
  endtask

  // Emit the current pixel, then take one Bresenham step along the major axis.
  task automatic advance_line();
    pixel_t                px;
    logic                  move_minor;
    logic [FIELD_BITS-1:0] y_next;
    int                    gain;
    if (!line_active) return;
    px.pixel_x    = cur_x;
    px.pixel_y    = cur_y;
    px.pixel_addr = ADDR_BITS'(int'(cur_y) * SCREEN_WIDTH + int'(cur_x));
    move_minor    = (decision >= 0);
    gain          = 2 * int'(delta_minor);
    if (move_minor) gain = gain - 2 * int'(delta_major);
    decision = (FIELD_BITS+3)'(int'(decision) + gain);
    y_next   = y_down ? cur_y + 1'b1 : cur_y - 1'b1;
    if (steep) begin
      if (move_minor) cur_x = cur_x + 1'b1;
      cur_y         = y_next;
      px.last_pixel = (cur_y == stop_major);
    end else begin
      if (move_minor) cur_y = y_next;
      cur_x         = cur_x + 1'b1;
      px.last_pixel = (cur_x == stop_major);
    end
    if (px.last_pixel) line_active = 1'b0;
    predicted_pixels.push_back(px);
  endtask

  task automatic report(input string field, input int want, input int got);
    failures++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (predicted_pixels.size() == 0) begin
      failures++;
      $display("%0t: unexpected pixel, expected none, actual x %0d y %0d", $time,
               pix.pixel_x, pix.pixel_y);
      return;
    end
    want = predicted_pixels.pop_front();
    if (pix.pixel_x !== want.pixel_x)
      report("pixel_x", int'(want.pixel_x), int'(pix.pixel_x));
    if (pix.pixel_y !== want.pixel_y)
      report("pixel_y", int'(want.pixel_y), int'(pix.pixel_y));
    if (pix.pixel_addr !== want.pixel_addr)
      report("pixel_addr", int'(want.pixel_addr), int'(pix.pixel_addr));
    if (pix.last_pixel !== want.last_pixel)
      report("last_pixel", int'(want.last_pixel), int'(pix.last_pixel));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_x       = '0;
      cur_y       = '0;
      stop_major  = '0;
      delta_major = '0;
      delta_minor = '0;
      decision    = '0;
      steep       = 1'b0;
      y_down      = 1'b0;
      line_active = 1'b0;
      predicted_pixels.delete();
    end else begin
      // A pixel leaving now was caused by an earlier request, so check first.
      if (pix.valid && pix.ready) check_pixel();
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LOAD)
          load_line('{req.req_type, req.start_x, req.start_y, req.end_x, req.end_y});
        else
          advance_line();
      end
    end
    pending    <= predicted_pixels.size();
    fail_count <= failures;
  end

endmodule

[dv/tb_line_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_rasterizer: testbench of the Bresenham line engine
// Drives load and step beats with random gaps and a randomly stalling pixel
// receiver; a scoreboard module predicts every pixel and counts mismatches.
// ----------------------------------------------------------------------------
module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int SCREEN_WIDTH = 1024;
  localparam int COORD_BITS   = 10;
  localparam int ITEM_GOAL    = 850;
  // Longest run of cycles without any beat on either channel that a healthy
  // block can show: the random request and receiver gaps plus the input and
  // output registers of the pipeline. The limit is set far above that.
  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_STEPS   = 48;

  logic clk;
  logic rst;

  lr_req_if req_ch();
  lr_pix_if pix_ch();

  int fail_count;
  int pending;
  int stall_cycles;

  // Counts loads and steps that hit an active line; idle steps do not count.
  int items_sent;
  // Pixels the current line still owes, tracked from the endpoints alone.
  int pixels_left;
  // While set, neither side inserts gaps, so back-to-back beats get covered.
  logic calm;

  line_rasterizer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .COORD_BITS   (COORD_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pix (pix_ch)
  );

  lr_pixel_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .pix        (pix_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a run in which nothing moves on either channel until the stall
  // counter reaches STALL_LIMIT is a hang.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Pixel receiver. For every beat it draws a random stall with ready low, then
  // holds ready high until the beat is taken. With no stall drawn, ready
  // simply stays high, so it is never dropped and raised in the same step.
  initial begin : pixel_sink
    int gap;
    pix_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        pix_ch.ready <= 1'b0;
        @(negedge clk);
      end
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
      @(negedge clk);
    end
  end

  function automatic logic [FIELD_BITS-1:0] clip_coord(input int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return FIELD_BITS'(v);
  endfunction

  // Send one request beat. Called at a falling edge and returns at the
  // falling edge after the beat was accepted.
  task automatic send_request(input logic kind, input logic [FIELD_BITS-1:0] sx,
                              input logic [FIELD_BITS-1:0] sy,
                              input logic [FIELD_BITS-1:0] ex,
                              input logic [FIELD_BITS-1:0] ey);
    int gap;
    int run_x;
    int run_y;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.start_x  <= sx;
    req_ch.start_y  <= sy;
    req_ch.end_x    <= ex;
    req_ch.end_y    <= ey;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk);
    if (kind == REQ_LOAD) begin
      run_x       = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      run_y       = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
      pixels_left = (run_x > run_y) ? run_x : run_y;
      items_sent++;
    end else if (pixels_left > 0) begin
      pixels_left--;
      items_sent++;
    end
  endtask

  // A step carries random endpoint fields, which the block must ignore.
  task automatic send_step();
    send_request(REQ_STEP, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                 FIELD_BITS'($urandom), FIELD_BITS'($urandom));
  endtask

  task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                           input int steps);
    send_request(REQ_LOAD, FIELD_BITS'(sx), FIELD_BITS'(sy), FIELD_BITS'(ex),
                 FIELD_BITS'(ey));
    repeat (steps) send_step();
  endtask

  initial begin : stimulus
    int sx, sy, ex, ey;
    int reach, run, extent, steps;
    logic left, up;

    rst             = 1'b1;
    calm            = 1'b0;
    items_sent      = 0;
    pixels_left     = 0;
    stall_cycles    = 0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.start_x  = '0;
    req_ch.start_y  = '0;
    req_ch.end_x    = '0;
    req_ch.end_y    = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A step right after reset finds no line and must be
    // dropped without a pixel.
    send_step();
    // Zero-length line: the load leaves no line active, so the step is idle.
    draw_line(0, 0, 0, 0, 1);
    // Endpoints given right to left at the bottom-right corner: the block swaps them
    // and walks a shallow line downward.
    draw_line(1023, 1023, 1020, 1021, 3);
    // Steep line running upward from the bottom edge, plus one idle step
    // once the line is finished.
    draw_line(0, 1023, 2, 1018, 6);
    // Vertical line on the right edge: the minor extent is zero.
    draw_line(1023, 0, 1023, 3, 3);
    // Horizontal line given right to left.
    draw_line(5, 9, 1, 9, 4);
    // A diagonal cut short by a new load, which must drop the old line.
    draw_line(100, 100, 110, 110, 2);
    draw_line(1023, 1023, 1021, 1023, 2);

    // Random part. Mostly well-formed lines of random placement and shape,
    // each followed by its steps; some get extra idle steps, some are cut
    // short by the next load, and some beats are pure noise.
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      if ($urandom_range(0, 9) < 8) begin
        sx = $urandom_range(0, 1023);
        sy = $urandom_range(0, 1023);
        if ($urandom_range(0, 15) == 0) begin
          ex = $urandom_range(0, 1023);
          ey = $urandom_range(0, 1023);
        end else begin
          reach = $urandom_range(0, 12);
          run   = ($urandom_range(0, 3) == 0) ? reach : $urandom_range(0, 12);
          left  = 1'($urandom_range(0, 1));
          up    = 1'($urandom_range(0, 1));
          ex    = int'(clip_coord(left ? sx - reach : sx + reach));
          ey    = int'(clip_coord(up ? sy - run : sy + run));
        end
        reach  = (ex > sx) ? ex - sx : sx - ex;
        run    = (ey > sy) ? ey - sy : sy - ey;
        extent = (reach > run) ? reach : run;
        case ($urandom_range(0, 9))
          0, 1: steps = extent + $urandom_range(1, 2);
          2: steps = (extent > 0) ? $urandom_range(0, extent - 1) : 0;
          default: steps = extent;
        endcase
        // Long lines are only walked part of the way to keep the run short.
        if (steps > LONG_STEPS) steps = LONG_STEPS;
        draw_line(sx, sy, ex, ey, steps);
      end else if ($urandom_range(0, 1) == 0) begin
        send_step();
      end else begin
        send_request(REQ_LOAD, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                     FIELD_BITS'($urandom), FIELD_BITS'($urandom));
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: the watchdog bounds this wait. Then allow for the pipeline
    // and a margin so that any stray pixel still shows up as a failure.
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lr_pkg.sv
rtl/core/lr_if.sv
rtl/core/lr_skid.sv
rtl/core/line_rasterizer.sv
dv/lr_pixel_checker.sv
dv/tb_line_rasterizer.sv
